// File: src/svgpd_pkg.sv
// Package with the token, segment and command types shared by the path decoder modules.
`timescale 1ns / 1ps

package svgpd_pkg;

	localparam int NumOps = 6;
	localparam int OpIdxW = 3;
	localparam int CoordW = 32;

	localparam logic [7:0] CHAR_M_UP = 8'h4D;
	localparam logic [7:0] CHAR_M_LO = 8'h6D;
	localparam logic [7:0] CHAR_L_UP = 8'h4C;
	localparam logic [7:0] CHAR_L_LO = 8'h6C;
	localparam logic [7:0] CHAR_H_UP = 8'h48;
	localparam logic [7:0] CHAR_H_LO = 8'h68;
	localparam logic [7:0] CHAR_V_UP = 8'h56;
	localparam logic [7:0] CHAR_V_LO = 8'h76;
	localparam logic [7:0] CHAR_C_UP = 8'h43;
	localparam logic [7:0] CHAR_C_LO = 8'h63;
	localparam logic [7:0] CHAR_S_UP = 8'h53;
	localparam logic [7:0] CHAR_S_LO = 8'h73;
	localparam logic [7:0] CHAR_Q_UP = 8'h51;
	localparam logic [7:0] CHAR_Q_LO = 8'h71;
	localparam logic [7:0] CHAR_Z_UP = 8'h5A;
	localparam logic [7:0] CHAR_Z_LO = 8'h7A;

	localparam logic TOKEN_LETTER = 1'b0;
	localparam logic TOKEN_NUMBER = 1'b1;

	typedef enum logic [3:0] {
		CMD_NONE  = 4'd0,
		CMD_M_ABS = 4'd1,
		CMD_M_REL = 4'd2,
		CMD_L_ABS = 4'd3,
		CMD_L_REL = 4'd4,
		CMD_H_ABS = 4'd5,
		CMD_H_REL = 4'd6,
		CMD_V_ABS = 4'd7,
		CMD_V_REL = 4'd8,
		CMD_C_ABS = 4'd9,
		CMD_C_REL = 4'd10,
		CMD_S_ABS = 4'd11,
		CMD_S_REL = 4'd12,
		CMD_Q_ABS = 4'd13,
		CMD_Q_REL = 4'd14
	} cmd_t;

	typedef enum logic [2:0] {
		SEG_MOVE  = 3'd0,
		SEG_LINE  = 3'd1,
		SEG_QUAD  = 3'd2,
		SEG_CUBIC = 3'd3,
		SEG_CLOSE = 3'd4,
		SEG_END   = 3'd5
	} seg_kind_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        symbol;
		logic [CoordW-1:0] value;
		logic              last;
	} token_t;

	typedef struct packed {
		seg_kind_t         kind;
		logic [CoordW-1:0] c1x;
		logic [CoordW-1:0] c1y;
		logic [CoordW-1:0] c2x;
		logic [CoordW-1:0] c2y;
		logic [CoordW-1:0] ex;
		logic [CoordW-1:0] ey;
		logic              eop;
	} seg_t;

	function automatic cmd_t letter_code(input logic [7:0] s);
		cmd_t c;
		case (s)
			CHAR_M_UP: c = CMD_M_ABS;
			CHAR_M_LO: c = CMD_M_REL;
			CHAR_L_UP: c = CMD_L_ABS;
			CHAR_L_LO: c = CMD_L_REL;
			CHAR_H_UP: c = CMD_H_ABS;
			CHAR_H_LO: c = CMD_H_REL;
			CHAR_V_UP: c = CMD_V_ABS;
			CHAR_V_LO: c = CMD_V_REL;
			CHAR_C_UP: c = CMD_C_ABS;
			CHAR_C_LO: c = CMD_C_REL;
			CHAR_S_UP: c = CMD_S_ABS;
			CHAR_S_LO: c = CMD_S_REL;
			CHAR_Q_UP: c = CMD_Q_ABS;
			CHAR_Q_LO: c = CMD_Q_REL;
			default:   c = CMD_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [OpIdxW-1:0] ops_needed(input cmd_t c);
		logic [OpIdxW-1:0] n;
		case (c)
			CMD_M_ABS, CMD_M_REL, CMD_L_ABS, CMD_L_REL: n = 3'd2;
			CMD_H_ABS, CMD_H_REL, CMD_V_ABS, CMD_V_REL: n = 3'd1;
			CMD_C_ABS, CMD_C_REL:                       n = 3'd6;
			CMD_S_ABS, CMD_S_REL, CMD_Q_ABS, CMD_Q_REL: n = 3'd4;
			default:                                    n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

// File: src/svg_path_command_decoder_top.sv
// Top level of the path command decoder: token register, interpreter and result register.
`timescale 1ns / 1ps

// The decoder takes one path token per cycle while out_ready does not stall the output,
// and gives at most one segment per token; the token is held in the input register and
// its segment then in the result register. The current point, control point and pending
// command state are updated as each token advances. A numeric token with no command
// pending is dropped, a letter where an operand is expected counts as zero, and the last
// token always yields a result with end_of_path set, after which the path state returns
// to its reset values.

module svg_path_command_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        token_kind,
	input  logic [7:0]  symbol,
	input  logic [31:0] number_value,
	input  logic        last_token,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  segment_kind,
	output logic [31:0] ctrl1_x,
	output logic [31:0] ctrl1_y,
	output logic [31:0] ctrl2_x,
	output logic [31:0] ctrl2_y,
	output logic [31:0] end_x,
	output logic [31:0] end_y,
	output logic        end_of_path
);

	svgpd_pkg::token_t tok_in, tok_s1;
	svgpd_pkg::seg_t   seg, seg_q;
	logic              valid_s1, advance, seg_valid;

	assign tok_in.kind   = token_kind;
	assign tok_in.symbol = symbol;
	assign tok_in.value  = number_value;
	assign tok_in.last   = last_token;

	assign advance = valid_s1 && (!out_valid || out_ready);

	svgpd_token_reg u_token_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.tok_in   (tok_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.tok_s1   (tok_s1)
	);

	svgpd_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok_s1),
		.fire      (advance),
		.seg       (seg),
		.seg_valid (seg_valid)
	);

	svgpd_result_reg u_result_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && seg_valid),
		.seg_in    (seg),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.seg_q     (seg_q)
	);

	assign segment_kind = seg_q.kind;
	assign ctrl1_x      = seg_q.c1x;
	assign ctrl1_y      = seg_q.c1y;
	assign ctrl2_x      = seg_q.c2x;
	assign ctrl2_y      = seg_q.c2y;
	assign end_x        = seg_q.ex;
	assign end_y        = seg_q.ey;
	assign end_of_path  = seg_q.eop;

endmodule

// File: src/svgpd_token_reg.sv
// Input register stage that holds one path token transaction.
`timescale 1ns / 1ps

module svgpd_token_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  svgpd_pkg::token_t tok_in,
	input  logic              advance,
	output logic              valid_s1,
	output svgpd_pkg::token_t tok_s1
);

	logic valid_q;

	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tok_s1 <= tok_in;
		end
	end

endmodule

// File: src/svgpd_interp.sv
// Path state and single-pass resolution of one token into at most one segment.
`timescale 1ns / 1ps

module svgpd_interp (
	input  logic              clk,
	input  logic              arst_n,
	input  svgpd_pkg::token_t tok,
	input  logic              fire,
	output svgpd_pkg::seg_t   seg,
	output logic              seg_valid
);

	logic [svgpd_pkg::CoordW-1:0] cur_x_q, cur_y_q, lc2_x_q, lc2_y_q;
	logic                         prev_cubic_q;
	svgpd_pkg::cmd_t              pend_q;
	logic [svgpd_pkg::OpIdxW-1:0] cnt_q;
	logic [svgpd_pkg::CoordW-1:0] buf_q [svgpd_pkg::NumOps];

	svgpd_pkg::cmd_t              new_cmd, exec_cmd;
	logic                         has_pend, do_exec, is_close, rel;
	logic [svgpd_pkg::OpIdxW-1:0] cnt_inc;
	logic [svgpd_pkg::CoordW-1:0] opnd_val, bx, by;
	logic [svgpd_pkg::CoordW-1:0] ops [svgpd_pkg::NumOps];

	always_comb begin
		new_cmd  = (tok.kind == svgpd_pkg::TOKEN_LETTER) ?
			svgpd_pkg::letter_code(tok.symbol) : svgpd_pkg::CMD_NONE;
		has_pend = (pend_q != svgpd_pkg::CMD_NONE);
		exec_cmd = has_pend ? pend_q : new_cmd;
		opnd_val = (tok.kind == svgpd_pkg::TOKEN_NUMBER) ? tok.value : '0;
		cnt_inc  = cnt_q + 3'd1;
		for (int i = 0; i < svgpd_pkg::NumOps; i++) begin
			if (has_pend && (3'(i) < cnt_q)) begin
				ops[i] = buf_q[i];
			end else if (has_pend && (3'(i) == cnt_q)) begin
				ops[i] = opnd_val;
			end else begin
				ops[i] = '0;
			end
		end
		do_exec  = has_pend ? ((cnt_inc >= svgpd_pkg::ops_needed(pend_q)) || tok.last) :
			((new_cmd != svgpd_pkg::CMD_NONE) && tok.last);
		is_close = !has_pend && (tok.kind == svgpd_pkg::TOKEN_LETTER) &&
			(new_cmd == svgpd_pkg::CMD_NONE) &&
			((tok.symbol == svgpd_pkg::CHAR_Z_UP) || (tok.symbol == svgpd_pkg::CHAR_Z_LO));
		rel = !exec_cmd[0];
		bx  = rel ? cur_x_q : '0;
		by  = rel ? cur_y_q : '0;
	end

	always_comb begin
		seg.kind = svgpd_pkg::SEG_END;
		seg.c1x  = '0;
		seg.c1y  = '0;
		seg.c2x  = '0;
		seg.c2y  = '0;
		seg.ex   = cur_x_q;
		seg.ey   = cur_y_q;
		seg.eop  = tok.last;
		if (do_exec) begin
			case (exec_cmd)
				svgpd_pkg::CMD_M_ABS, svgpd_pkg::CMD_M_REL: begin
					seg.kind = svgpd_pkg::SEG_MOVE;
					seg.ex   = bx + ops[0];
					seg.ey   = by + ops[1];
				end
				svgpd_pkg::CMD_L_ABS, svgpd_pkg::CMD_L_REL: begin
					seg.kind = svgpd_pkg::SEG_LINE;
					seg.ex   = bx + ops[0];
					seg.ey   = by + ops[1];
				end
				svgpd_pkg::CMD_H_ABS, svgpd_pkg::CMD_H_REL: begin
					seg.kind = svgpd_pkg::SEG_LINE;
					seg.ex   = bx + ops[0];
				end
				svgpd_pkg::CMD_V_ABS, svgpd_pkg::CMD_V_REL: begin
					seg.kind = svgpd_pkg::SEG_LINE;
					seg.ey   = by + ops[0];
				end
				svgpd_pkg::CMD_C_ABS, svgpd_pkg::CMD_C_REL: begin
					seg.kind = svgpd_pkg::SEG_CUBIC;
					seg.c1x  = bx + ops[0];
					seg.c1y  = by + ops[1];
					seg.c2x  = bx + ops[2];
					seg.c2y  = by + ops[3];
					seg.ex   = bx + ops[4];
					seg.ey   = by + ops[5];
				end
				svgpd_pkg::CMD_S_ABS, svgpd_pkg::CMD_S_REL: begin
					seg.kind = svgpd_pkg::SEG_CUBIC;
					if (prev_cubic_q) begin
						seg.c1x = {cur_x_q[svgpd_pkg::CoordW-2:0], 1'b0} - lc2_x_q;
						seg.c1y = {cur_y_q[svgpd_pkg::CoordW-2:0], 1'b0} - lc2_y_q;
					end else begin
						seg.c1x = cur_x_q;
						seg.c1y = cur_y_q;
					end
					seg.c2x = bx + ops[0];
					seg.c2y = by + ops[1];
					seg.ex  = bx + ops[2];
					seg.ey  = by + ops[3];
				end
				default: begin
					seg.kind = svgpd_pkg::SEG_QUAD;
					seg.c1x  = bx + ops[0];
					seg.c1y  = by + ops[1];
					seg.ex   = bx + ops[2];
					seg.ey   = by + ops[3];
				end
			endcase
		end else if (is_close) begin
			seg.kind = svgpd_pkg::SEG_CLOSE;
		end
	end

	assign seg_valid = do_exec || is_close || tok.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			lc2_x_q      <= '0;
			lc2_y_q      <= '0;
			prev_cubic_q <= 1'b0;
			pend_q       <= svgpd_pkg::CMD_NONE;
			cnt_q        <= '0;
		end else if (fire) begin
			if (tok.last) begin
				cur_x_q      <= '0;
				cur_y_q      <= '0;
				lc2_x_q      <= '0;
				lc2_y_q      <= '0;
				prev_cubic_q <= 1'b0;
				pend_q       <= svgpd_pkg::CMD_NONE;
				cnt_q        <= '0;
			end else if (do_exec) begin
				cur_x_q      <= seg.ex;
				cur_y_q      <= seg.ey;
				prev_cubic_q <= (seg.kind == svgpd_pkg::SEG_CUBIC);
				if (seg.kind == svgpd_pkg::SEG_CUBIC) begin
					lc2_x_q <= seg.c2x;
					lc2_y_q <= seg.c2y;
				end
				pend_q <= svgpd_pkg::CMD_NONE;
				cnt_q  <= '0;
			end else if (is_close) begin
				prev_cubic_q <= 1'b0;
			end else if (has_pend) begin
				cnt_q <= cnt_inc;
			end else if (new_cmd != svgpd_pkg::CMD_NONE) begin
				pend_q <= new_cmd;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_pend && !do_exec) begin
			buf_q[cnt_q] <= opnd_val;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && tok.last |=> (pend_q == svgpd_pkg::CMD_NONE) && (cnt_q == '0))
		else $error("pending command survived the last token");

	a_cnt_below_need: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != svgpd_pkg::CMD_NONE) |-> (cnt_q < svgpd_pkg::ops_needed(pend_q)))
		else $error("operand count reached the command's operand need");

	a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == svgpd_pkg::CMD_NONE) |-> (cnt_q == '0))
		else $error("operand count nonzero with no pending command");

endmodule

// File: src/svgpd_result_reg.sv
// Output register that holds one segment transaction until it is taken.
`timescale 1ns / 1ps

module svgpd_result_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  svgpd_pkg::seg_t seg_in,
	input  logic            out_ready,
	output logic            out_valid,
	output svgpd_pkg::seg_t seg_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seg_q <= seg_in;
		end
	end

endmodule
